// ----- rtl/bli_pkg.sv -----
`timescale 1ns / 1ps

package bli_pkg;

	// Q16.16 data word
	localparam int DATA_W = 32;
	localparam int PROD_W = 2 * DATA_W;

	// default table depth
	localparam int MAX_POINTS_DEF = 64;

	// one quotient bit per divider step
	localparam int DIV_STEPS = DATA_W;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

	typedef logic signed [DATA_W-1:0] q16_t;
	typedef logic [DATA_W-1:0]        mag_t;
	typedef logic [PROD_W-1:0]        prod_t;
	typedef logic [1:0]               status_t;

	// command codes
	localparam logic CMD_INSERT = 1'b0;
	localparam logic CMD_EVAL   = 1'b1;

	// result status codes
	localparam status_t ST_EVAL    = 2'd0;
	localparam status_t ST_INSERT  = 2'd1;
	localparam status_t ST_REPLACE = 2'd2;
	localparam status_t ST_FULL    = 2'd3;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

// ----- rtl/bli_if.sv -----
`timescale 1ns / 1ps

interface bli_cmd_if;
	import bli_pkg::*;

	logic valid;
	logic ready;
	logic command;
	q16_t point_x;
	q16_t point_y;

	modport source (output valid, output command, output point_x, output point_y, input ready);
	modport sink (input valid, input command, input point_x, input point_y, output ready);
endinterface

interface bli_res_if;
	import bli_pkg::*;

	logic    valid;
	logic    ready;
	q16_t    value;
	status_t status;

	modport source (output valid, output value, output status, input ready);
	modport sink (input valid, input value, input status, output ready);
endinterface

// ----- rtl/breakpoint_linear_interpolator.sv -----
`timescale 1ns / 1ps

// Piecewise-linear breakpoint function over signed Q16.16 values.
// Channel cmd (sink): command 0 inserts (point_x, point_y) in x order or
// replaces the y of an equal x; command 1 evaluates the function at point_x.
// Channel res (source): one item per command, value and status
// (0 evaluated, 1 inserted, 2 replaced, 3 table full so the point was dropped).
// An item is taken when valid and ready are high at a rising edge of clk.
// cmd.ready is high only while the sequencer is idle; one command at a time.
// Steps per command:
//   linear search over the stored points, stopping at the first larger x,
//   insert with shift: each entry above the new point moves up one row,
//   evaluate between points: 2 table reads, 1 multiply, 1 divider load and
//   the divider run (one quotient bit per cycle, then the quotient).
// The result sits in an output register; the next command is accepted while
// it waits. A stalled receiver only holds the sequencer when a second result
// is ready before the first is taken.
// Reset (arst_n low) empties the table and drops any pending result; the
// table memory itself is not cleared, entries beyond the count are never used.
module breakpoint_linear_interpolator #(
	parameter int MAX_POINTS = bli_pkg::MAX_POINTS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	bli_cmd_if.sink   cmd,
	bli_res_if.source res
);
	import bli_pkg::*;

	localparam int IW = $clog2(MAX_POINTS);
	localparam int CW = $clog2(MAX_POINTS + 1);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_SRCH  = 4'd1;
	localparam logic [3:0] S_DEC   = 4'd2;
	localparam logic [3:0] S_SHIFT = 4'd3;
	localparam logic [3:0] S_EV1   = 4'd4;
	localparam logic [3:0] S_EV2   = 4'd5;
	localparam logic [3:0] S_MUL   = 4'd6;
	localparam logic [3:0] S_DIV   = 4'd7;
	localparam logic [3:0] S_DIVW  = 4'd8;
	localparam logic [3:0] S_DONE  = 4'd9;

	logic [3:0]    state_q;
	logic [CW-1:0] count_q;

	// captured command
	logic cmd_q;
	q16_t px_q;
	q16_t py_q;

	// search and shift bookkeeping
	logic [IW-1:0] ra_q;
	logic          iss_q;
	logic          rv_s1;
	logic [IW-1:0] ri_s1;
	logic [CW-1:0] pos_q;
	logic          eq_q;
	logic [CW-1:0] rem_q;
	logic [IW-1:0] sa_q;

	// interpolation operands
	q16_t  xl_q;
	q16_t  yl_q;
	mag_t  dx_q;
	mag_t  span_q;
	mag_t  mag_q;
	logic  neg_q;
	prod_t prod_q;

	// pending and presented results
	q16_t    res_val_q;
	status_t res_st_q;
	logic    ovld_q;
	q16_t    value_q;
	status_t status_q;

	// table port
	logic [IW-1:0] rd_addr;
	q16_t          rd_x;
	q16_t          rd_y;
	logic          wr_en;
	logic [IW-1:0] wr_addr;
	q16_t          wr_x;
	q16_t          wr_y;

	// divider
	logic      div_start;
	mag_t      div_q;
	div_stat_t div_stat;

	logic [CW-1:0]   pos_m1;
	logic [CW-1:0]   count_m1;
	logic [DATA_W:0] dy;
	logic [DATA_W:0] dy_abs;

	assign pos_m1   = pos_q - CW'(1);
	assign count_m1 = count_q - CW'(1);
	assign dy       = {rd_y[DATA_W-1], rd_y} - {yl_q[DATA_W-1], yl_q};
	assign dy_abs   = dy[DATA_W] ? (~dy + (DATA_W+1)'(1)) : dy;

	bli_table #(
		.DEPTH (MAX_POINTS),
		.IW    (IW)
	) u_table (
		.clk     (clk),
		.rd_addr (rd_addr),
		.rd_x    (rd_x),
		.rd_y    (rd_y),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_x    (wr_x),
		.wr_y    (wr_y)
	);

	bli_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (prod_q),
		.divisor  (span_q),
		.quotient (div_q),
		.stat     (div_stat)
	);

	// read address: scan up, shift down, or fetch the bracketing pair
	always_comb begin
		unique case (state_q)
			S_SRCH:  rd_addr = ra_q;
			S_SHIFT: rd_addr = sa_q;
			S_DEC:   rd_addr = (pos_q == '0) ? '0 : pos_m1[IW-1:0];
			S_EV1:   rd_addr = pos_q[IW-1:0];
			default: rd_addr = '0;
		endcase
	end

	// table writes: replace in place, move an entry up, or drop in the new point
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = pos_q[IW-1:0];
		wr_x    = px_q;
		wr_y    = py_q;
		unique case (state_q)
			S_DEC: begin
				if (cmd_q == CMD_INSERT) begin
					if (eq_q) begin
						wr_en   = 1'b1;
						wr_addr = pos_m1[IW-1:0];
					end else if (count_q != CW'(MAX_POINTS) && count_q == pos_q) begin
						wr_en = 1'b1;
					end
				end
			end
			S_SHIFT: begin
				if (rv_s1) begin
					wr_en   = 1'b1;
					wr_addr = ri_s1 + IW'(1);
					wr_x    = rd_x;
					wr_y    = rd_y;
				end else if (rem_q == '0) begin
					wr_en = 1'b1;
				end
			end
			default: wr_en = 1'b0;
		endcase
	end

	assign div_start = (state_q == S_DIV);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			ovld_q  <= 1'b0;
			iss_q   <= 1'b0;
			rv_s1   <= 1'b0;
		end else begin
			if (res.valid && res.ready) begin
				ovld_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (cmd.valid) begin
						cmd_q <= cmd.command;
						px_q  <= cmd.point_x;
						py_q  <= cmd.point_y;
						eq_q  <= 1'b0;
						ra_q  <= '0;
						rv_s1 <= 1'b0;
						pos_q <= '0;
						if (count_q == '0) begin
							iss_q   <= 1'b0;
							state_q <= S_DEC;
						end else begin
							iss_q   <= 1'b1;
							state_q <= S_SRCH;
						end
					end
				end
				S_SRCH: begin
					// issue one read a cycle, compare the entry read last cycle
					rv_s1 <= iss_q;
					ri_s1 <= ra_q;
					if (iss_q) begin
						ra_q  <= ra_q + IW'(1);
						iss_q <= (CW'(ra_q) + CW'(1)) < count_q;
					end
					if (rv_s1) begin
						if (rd_x > px_q) begin
							pos_q   <= CW'(ri_s1);
							iss_q   <= 1'b0;
							rv_s1   <= 1'b0;
							state_q <= S_DEC;
						end else begin
							if (rd_x == px_q) begin
								eq_q <= 1'b1;
							end
							if (CW'(ri_s1) == count_m1) begin
								pos_q   <= count_q;
								iss_q   <= 1'b0;
								rv_s1   <= 1'b0;
								state_q <= S_DEC;
							end
						end
					end
				end
				S_DEC: begin
					res_val_q <= '0;
					if (cmd_q == CMD_INSERT) begin
						if (eq_q) begin
							res_st_q <= ST_REPLACE;
							state_q  <= S_DONE;
						end else if (count_q == CW'(MAX_POINTS)) begin
							res_st_q <= ST_FULL;
							state_q  <= S_DONE;
						end else if (count_q == pos_q) begin
							count_q  <= count_q + CW'(1);
							res_st_q <= ST_INSERT;
							state_q  <= S_DONE;
						end else begin
							rem_q   <= count_q - pos_q;
							sa_q    <= count_m1[IW-1:0];
							rv_s1   <= 1'b0;
							state_q <= S_SHIFT;
						end
					end else begin
						res_st_q <= ST_EVAL;
						if (count_q == '0) begin
							state_q <= S_DONE;
						end else begin
							state_q <= S_EV1;
						end
					end
				end
				S_SHIFT: begin
					// move entries up from the top, one per cycle
					rv_s1 <= (rem_q != '0);
					ri_s1 <= sa_q;
					if (rem_q != '0) begin
						sa_q  <= sa_q - IW'(1);
						rem_q <= rem_q - CW'(1);
					end else if (!rv_s1) begin
						count_q  <= count_q + CW'(1);
						res_st_q <= ST_INSERT;
						state_q  <= S_DONE;
					end
				end
				S_EV1: begin
					// clamp below the first and at or beyond the last point
					if (pos_q == '0 || pos_q == count_q) begin
						res_val_q <= rd_y;
						state_q   <= S_DONE;
					end else begin
						xl_q    <= rd_x;
						yl_q    <= rd_y;
						state_q <= S_EV2;
					end
				end
				S_EV2: begin
					dx_q    <= mag_t'(px_q - xl_q);
					span_q  <= mag_t'(rd_x - xl_q);
					neg_q   <= dy[DATA_W];
					mag_q   <= dy_abs[DATA_W-1:0];
					state_q <= S_MUL;
				end
				S_MUL: begin
					prod_q  <= PROD_W'(dx_q) * PROD_W'(mag_q);
					state_q <= S_DIV;
				end
				S_DIV: begin
					state_q <= S_DIVW;
				end
				S_DIVW: begin
					if (div_stat.done) begin
						res_val_q <= neg_q ? (yl_q - q16_t'(div_q)) : (yl_q + q16_t'(div_q));
						state_q   <= S_DONE;
					end
				end
				S_DONE: begin
					// hold until the output register is free
					if (!ovld_q || res.ready) begin
						ovld_q   <= 1'b1;
						value_q  <= res_val_q;
						status_q <= res_st_q;
						state_q  <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign cmd.ready  = (state_q == S_IDLE);
	assign res.valid  = ovld_q;
	assign res.value  = value_q;
	assign res.status = status_q;

`ifndef SYNTHESIS
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_POINTS))
		else $error("point count beyond table depth");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != $past(count_q) |-> count_q == $past(count_q) + CW'(1))
		else $error("point count changed by other than one");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.valid && cmd.ready |=> !cmd.ready)
		else $error("command accepted while another is in progress");

	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_stat.busy)
		else $error("divider started while busy");
`endif

endmodule

// ----- rtl/bli_table.sv -----
`timescale 1ns / 1ps

module bli_table #(
	parameter int DEPTH = bli_pkg::MAX_POINTS_DEF,
	parameter int IW    = $clog2(DEPTH)
) (
	input  logic           clk,
	input  logic [IW-1:0]  rd_addr,
	output bli_pkg::q16_t  rd_x,
	output bli_pkg::q16_t  rd_y,
	input  logic           wr_en,
	input  logic [IW-1:0]  wr_addr,
	input  bli_pkg::q16_t  wr_x,
	input  bli_pkg::q16_t  wr_y
);
	import bli_pkg::*;

	// x and y of one breakpoint share a row
	logic [2*DATA_W-1:0] mem [DEPTH];
	logic [2*DATA_W-1:0] rd_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= {wr_x, wr_y};
		end
	end

	always_ff @(posedge clk) begin
		rd_q <= mem[rd_addr];
	end

	assign rd_x = rd_q[2*DATA_W-1:DATA_W];
	assign rd_y = rd_q[DATA_W-1:0];

endmodule

// ----- rtl/bli_div.sv -----
`timescale 1ns / 1ps

module bli_div (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  bli_pkg::prod_t      dividend,
	input  bli_pkg::mag_t       divisor,
	output bli_pkg::mag_t       quotient,
	output bli_pkg::div_stat_t  stat
);
	import bli_pkg::*;

	// Restoring division, one quotient bit per cycle. The caller guarantees
	// that the upper half of the dividend is below the divisor, so the
	// quotient fits in DATA_W bits and the remainder never exceeds it.
	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	mag_t                 rem_q;
	mag_t                 quo_q;
	mag_t                 dsr_q;
	logic [DATA_W:0]      trial;
	logic [DATA_W:0]      diff;
	logic                 ge;

	assign trial = {rem_q, quo_q[DATA_W-1]};
	assign diff  = trial - {1'b0, dsr_q};
	assign ge    = (trial >= {1'b0, dsr_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
				rem_q  <= dividend[PROD_W-1:DATA_W];
				quo_q  <= dividend[DATA_W-1:0];
				dsr_q  <= divisor;
			end else if (busy_q) begin
				// shift in the next dividend bit, subtract when it fits
				rem_q <= ge ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
				quo_q <= {quo_q[DATA_W-2:0], ge};
				cnt_q <= cnt_q + DIV_CNT_W'(1);
				if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign quotient  = quo_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

// ----- tb/bli_checker.sv -----
`timescale 1ns / 1ps

module bli_checker #(
	parameter int MAX_POINTS = bli_pkg::MAX_POINTS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	bli_cmd_if   cmd_tap,
	bli_res_if   res_tap,
	output int   mismatch_count,
	output int   awaited_count
);
	import bli_pkg::*;

	typedef struct packed {
		q16_t    value;
		status_t status;
	} bli_result_t;

	// shadow breakpoint table, sorted by ascending x
	q16_t knot_x [MAX_POINTS];
	q16_t knot_y [MAX_POINTS];
	int   knot_count = 0;

	bli_result_t awaited_results [$];
	int          fails = 0;

	// value on the segment from entry lo to entry lo+1, quotient truncated toward zero
	function automatic q16_t segment_value(int lo, q16_t px);
		longint      xl, yl, dy;
		logic [63:0] dx, span, mag, quot;
		xl   = longint'(knot_x[lo]);
		yl   = longint'(knot_y[lo]);
		dx   = longint'(px) - xl;
		span = longint'(knot_x[lo+1]) - xl;
		dy   = longint'(knot_y[lo+1]) - yl;
		mag  = (dy < 0) ? -dy : dy;
		quot = (dx * mag) / span;
		if (dy < 0)
			return q16_t'(yl - longint'(quot));
		return q16_t'(yl + longint'(quot));
	endfunction

	// update the shadow table and return the result the block must give
	function automatic bli_result_t apply_command(logic command, q16_t px, q16_t py);
		bli_result_t outcome;
		int          above;
		int          k;
		outcome.value  = '0;
		outcome.status = ST_EVAL;
		above = 0;
		while (above < knot_count && knot_x[above] <= px)
			above++;
		if (command == CMD_INSERT) begin
			if (above > 0 && knot_x[above-1] == px) begin
				knot_y[above-1] = py;
				outcome.status  = ST_REPLACE;
			end else if (knot_count >= MAX_POINTS) begin
				outcome.status = ST_FULL;
			end else begin
				for (k = knot_count; k > above; k--) begin
					knot_x[k] = knot_x[k-1];
					knot_y[k] = knot_y[k-1];
				end
				knot_x[above]  = px;
				knot_y[above]  = py;
				knot_count++;
				outcome.status = ST_INSERT;
			end
		end else if (knot_count == 0) begin
			outcome.value = '0;
		end else if (above == 0) begin
			outcome.value = knot_y[0];
		end else if (above >= knot_count) begin
			outcome.value = knot_y[knot_count-1];
		end else begin
			outcome.value = segment_value(above - 1, px);
		end
		return outcome;
	endfunction

	task automatic flag(input string msg);
		fails++;
		if (fails <= 10)
			$display("%0t: %s", $time, msg);
	endtask

	always @(posedge clk) begin
		bli_result_t want;
		if (arst_n) begin
			// results first: a command taken at this edge cannot answer at the same edge
			if (res_tap.valid && res_tap.ready) begin
				if (awaited_results.size() == 0) begin
					flag($sformatf("unexpected result value %h status %0d",
						res_tap.value, res_tap.status));
				end else begin
					want = awaited_results.pop_front();
					if (res_tap.value !== want.value || res_tap.status !== want.status)
						flag($sformatf("value expected %h got %h, status expected %0d got %0d",
							want.value, res_tap.value, want.status, res_tap.status));
				end
			end
			if (cmd_tap.valid && cmd_tap.ready)
				awaited_results.push_back(apply_command(cmd_tap.command,
					cmd_tap.point_x, cmd_tap.point_y));
		end
		mismatch_count <= fails;
		awaited_count  <= awaited_results.size();
	end

endmodule

// ----- tb/breakpoint_linear_interpolator_tb.sv -----
`timescale 1ns / 1ps

module breakpoint_linear_interpolator_tb;
	import bli_pkg::*;

	localparam int   RANDOM_ITEMS = 1350;
	// keep a wide margin over the slowest run of roughly 1400 items
	localparam int   CYCLE_LIMIT  = 1_000_000;
	// drain well past the slowest command with a full table of 64 points
	localparam int   DRAIN_CYCLES = 300;
	localparam int   STALL_CYCLES = 800;
	localparam q16_t Q_MIN = 32'h8000_0000;
	localparam q16_t Q_MAX = 32'h7fff_ffff;
	localparam q16_t Q_ONE = 32'h0001_0000;

	logic clk;
	logic arst_n;

	// idle chance per cycle, in percent, for each side
	int   tx_idle_pct = 21;
	int   rx_idle_pct = 60;
	logic rx_hold     = 1'b0;
	int   items_sent  = 0;
	int   cycle_count = 0;
	int   mismatch_count;
	int   awaited_count;

	// every x ever offered for insert, used to aim replaces and evaluations
	q16_t known_x [$];

	bli_cmd_if cmd_ch ();
	bli_res_if res_ch ();

	breakpoint_linear_interpolator uut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch),
		.res    (res_ch)
	);

	bli_checker bli_chk (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd_tap        (cmd_ch),
		.res_tap        (res_ch),
		.mismatch_count (mismatch_count),
		.awaited_count  (awaited_count)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Offer one item and hold it until the block takes it. Idle gaps go in
	// front of the item; with no gap, valid simply stays high for the next one.
	task automatic send_item(input logic command, input q16_t px, input q16_t py);
		int gap;
		gap = 0;
		while ($urandom_range(0, 99) < tx_idle_pct)
			gap++;
		if (gap > 0) begin
			cmd_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_ch.valid   <= 1'b1;
		cmd_ch.command <= command;
		cmd_ch.point_x <= px;
		cmd_ch.point_y <= py;
		@(posedge clk);
		while (!cmd_ch.ready)
			@(posedge clk);
		items_sent++;
		if (command == CMD_INSERT)
			known_x.push_back(px);
	endtask

	// Pick an x within spread of one already offered; spread 0 hits it exactly.
	function automatic q16_t near_known(int spread);
		if (known_x.size() == 0)
			return q16_t'($urandom);
		return known_x[$urandom_range(0, known_x.size() - 1)]
			+ q16_t'(int'($urandom_range(0, 2 * spread)) - spread);
	endfunction

	// Receiver: drop ready at random, and hold it low entirely during a stall.
	initial begin
		res_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			res_ch.ready <= !rx_hold && ($urandom_range(0, 99) >= rx_idle_pct);
		end
	end

	// Long receiver stalls while the sender keeps offering: the output register
	// fills, the next result completes behind it, and the block stops taking items.
	initial begin
		int stall_at [2];
		int held;
		stall_at = '{150, 1100};
		foreach (stall_at[i]) begin
			wait (items_sent >= stall_at[i]);
			@(posedge clk);
			rx_hold <= 1'b1;
			held = 0;
			while (held < STALL_CYCLES) begin
				@(posedge clk);
				held++;
			end
			rx_hold <= 1'b0;
		end
	end

	// Watchdog: end the run if the block hangs.
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("breakpoint_linear_interpolator test failed");
		$finish;
	end

	initial begin
		int   n;
		int   pick;
		q16_t px;
		q16_t py;

		arst_n         = 1'b0;
		cmd_ch.valid   = 1'b0;
		cmd_ch.command = CMD_INSERT;
		cmd_ch.point_x = '0;
		cmd_ch.point_y = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part.
		// Evaluate on an empty table: value must be zero.
		send_item(CMD_EVAL, 0, 0);
		send_item(CMD_EVAL, Q_MIN, Q_MAX);
		// One point: below, at and beyond it all clamp to its y.
		send_item(CMD_INSERT, 5 * Q_ONE, 3 * Q_ONE);
		send_item(CMD_EVAL, 0, Q_MIN);
		send_item(CMD_EVAL, 5 * Q_ONE, 0);
		send_item(CMD_EVAL, Q_MAX, 0);
		// Extreme ends of x with extreme y: widest span and steepest slopes.
		send_item(CMD_INSERT, Q_MIN, Q_MAX);
		send_item(CMD_INSERT, Q_MAX, Q_MIN);
		send_item(CMD_EVAL, Q_MIN, 0);
		send_item(CMD_EVAL, Q_MIN + 1, 0);
		send_item(CMD_EVAL, 0, 0);
		send_item(CMD_EVAL, Q_MAX - 1, 0);
		send_item(CMD_EVAL, Q_MAX, 0);
		// Equal x replaces the y in place.
		send_item(CMD_INSERT, 5 * Q_ONE, -Q_ONE);
		send_item(CMD_INSERT, Q_MIN, Q_MIN);
		// Close neighbors: a falling slope whose quotient truncates toward zero.
		send_item(CMD_INSERT, -1, 0);
		send_item(CMD_INSERT, 1, -1);
		send_item(CMD_EVAL, 0, Q_MAX);
		send_item(CMD_INSERT, 3, Q_MAX);
		send_item(CMD_EVAL, 2, 0);
		send_item(CMD_EVAL, 6 * Q_ONE, 0);
		send_item(CMD_EVAL, -2, 0);

		// Random part. The table fills after a few dozen new x values; from then
		// on new inserts are dropped, while replaces and evaluations keep going.
		for (n = 0; n < RANDOM_ITEMS; n++) begin
			if (n == RANDOM_ITEMS / 3) begin
				tx_idle_pct = 60;
				rx_idle_pct = 21;
			end
			if (n == 2 * RANDOM_ITEMS / 3) begin
				tx_idle_pct = 0;
				rx_idle_pct = 0;
			end
			pick = $urandom_range(0, 99);
			py   = q16_t'($urandom);
			if ($urandom_range(0, 3) == 0)
				py = q16_t'(int'($urandom_range(0, 1 << 20)) - (1 << 19));
			if (pick < 25) begin
				send_item(CMD_INSERT, q16_t'($urandom), py);
			end else if (pick < 40) begin
				send_item(CMD_INSERT, near_known(1 << 16), py);
			end else if (pick < 52) begin
				send_item(CMD_INSERT, near_known(0), py);
			end else if (pick < 70) begin
				send_item(CMD_EVAL, near_known(4), py);
			end else if (pick < 85) begin
				send_item(CMD_EVAL, near_known(1 << 18), py);
			end else if (pick < 93) begin
				send_item(CMD_EVAL, q16_t'($urandom), py);
			end else begin
				px = pick[0] ? Q_MIN : Q_MAX;
				send_item(CMD_EVAL, px, py);
			end
		end
		cmd_ch.valid <= 1'b0;

		// Let the checker see the last item, collect every result, then linger
		// in case the block sends anything extra.
		@(posedge clk);
		while (awaited_count != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatch_count == 0 && awaited_count == 0) begin
			$display("breakpoint_linear_interpolator test passed");
		end else begin
			if (awaited_count != 0)
				$display("%0d expected results never arrived", awaited_count);
			$display("breakpoint_linear_interpolator test failed");
		end
		$finish;
	end

endmodule

// ----- filelist.f -----
rtl/bli_pkg.sv
rtl/bli_if.sv
rtl/bli_table.sv
rtl/bli_div.sv
rtl/breakpoint_linear_interpolator.sv
tb/bli_checker.sv
tb/breakpoint_linear_interpolator_tb.sv
